/* sv/jlvs_pkg.sv */
// Package: widths, register indexes and sequencer states of the velocity shaper.
package jlvs_pkg;

  localparam int VALUE_W  = 32;
  localparam int CFG_W    = 31;
  localparam int DT_W     = 16;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int CIDX_W   = 2;

  typedef enum logic [CIDX_W-1:0] {
    CFG_ACCEL_LIMIT  = 2'd0,
    CFG_JERK_LIMIT   = 2'd1,
    CFG_COMMAND_GAIN = 2'd2
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST  = 31'd163840;
  localparam logic [CFG_W-1:0] JERK_LIMIT_RST   = 31'd524288;
  localparam logic [CFG_W-1:0] COMMAND_GAIN_RST = 31'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_JERK,
    ST_ERR,
    ST_GMUL,
    ST_DES,
    ST_ACC,
    ST_LIM,
    ST_VMUL,
    ST_VADD,
    ST_OUT
  } state_t;

endpackage

/* sv/jlvs_in_if.sv */
// Interface: input channel carrying the two velocity commands and the time step.
interface jlvs_in_if import jlvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] x_command;
  logic signed [VALUE_W-1:0] y_command;
  logic        [DT_W-1:0]    time_step;

  modport source (output valid, x_command, y_command, time_step, input ready);
  modport sink   (input valid, x_command, y_command, time_step, output ready);
endinterface

/* sv/jlvs_out_if.sv */
// Interface: result channel carrying the two shaped velocities.
interface jlvs_out_if import jlvs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] x_shaped;
  logic signed [VALUE_W-1:0] y_shaped;

  modport source (output valid, x_shaped, y_shaped, input ready);
  modport sink   (input valid, x_shaped, y_shaped, output ready);
endinterface

/* sv/jerk_limited_velocity_shaper.sv */
// Top level: two-axis jerk-limited velocity shaper on one shared multiplier.
//
//   channel  | dir | transaction contents
//   ---------+-----+-------------------------------------------
//   in_if    | in  | x_command, y_command, time_step
//   out_if   | out | x_shaped, y_shaped
//   cfg_*    | in  | cfg_index, cfg_data (write only)
//
// A result is valid after its transaction has passed one jerk-bound multiply,
// seven steps per axis (error, gain multiply, saturate, jerk clamp, accel
// clamp, dt multiply, velocity add) on the single 32x32 multiplier, and the
// load of the output register. The next transaction is taken only once the
// result is loaded and the sequencer is back in idle; in_if.ready is high only
// while idle. A stalled output holds the sequencer in its last step. Reset
// (synchronous) zeroes all axis state and restores the register defaults.
module jerk_limited_velocity_shaper import jlvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  jlvs_in_if.sink           in_if,
  jlvs_out_if.source        out_if,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  state_t state_r, state_nxt;
  logic   axis_r;

  logic [CFG_W-1:0] accel_limit_r, jerk_limit_r, command_gain_r;

  logic signed [VALUE_W-1:0] vel_r [2];
  logic signed [VALUE_W-1:0] acc_r [2];

  logic signed [VALUE_W-1:0] xcmd_r, ycmd_r;
  logic        [DT_W-1:0]    dt_r;

  logic        [CFG_W-1:0]   jlim_r;
  logic        [VALUE_W-1:0] mag_r;
  logic                      neg_r;
  logic        [PROD_W-1:0]  prod_r;
  logic signed [VALUE_W:0]   da_r;
  logic signed [VALUE_W+1:0] sum_r;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] x_out_r, y_out_r;

  logic               in_ready;
  logic               out_free;
  logic               out_load;
  logic [VALUE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;

  assign out_free = !out_valid_r || out_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_if.valid) state_nxt = ST_JERK;
      ST_JERK: state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_GMUL;
      ST_GMUL: state_nxt = ST_DES;
      ST_DES:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_LIM;
      ST_LIM:  state_nxt = ST_VMUL;
      ST_VMUL: state_nxt = ST_VADD;
      ST_VADD: state_nxt = axis_r ? ST_OUT : ST_ERR;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mul_a    = mag_r;
    mul_b    = {{(VALUE_W-DT_W){1'b0}}, dt_r};
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_JERK: mul_a = {{(VALUE_W-CFG_W){1'b0}}, jerk_limit_r};
      ST_GMUL: mul_b = {{(VALUE_W-CFG_W){1'b0}}, command_gain_r};
      ST_OUT:  out_load = out_free;
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // datapath step values
  logic signed [VALUE_W-1:0] cmd_sel, vel_sel, acc_sel;
  logic signed [VALUE_W:0]   err;
  logic        [PROD_W-FRAC_W-1:0] pm;
  logic signed [VALUE_W-1:0] a_des;
  logic signed [VALUE_W:0]   jl, dac;
  logic signed [VALUE_W+1:0] alim, a_lim;
  logic        [VALUE_W-1:0] step;
  logic signed [VALUE_W+1:0] sv, nv;
  logic signed [VALUE_W-1:0] vel_new;

  always_comb begin
    cmd_sel = axis_r ? ycmd_r : xcmd_r;
    vel_sel = vel_r[axis_r];
    acc_sel = acc_r[axis_r];
    err = {cmd_sel[VALUE_W-1], cmd_sel} - {vel_sel[VALUE_W-1], vel_sel};

    pm = prod_r[PROD_W-1:FRAC_W];
    if (neg_r) begin
      if (pm >= (PROD_W-FRAC_W)'(64'h8000_0000)) a_des = {1'b1, {(VALUE_W-1){1'b0}}};
      else a_des = -$signed(pm[VALUE_W-1:0]);
    end else begin
      if (pm >= (PROD_W-FRAC_W)'(64'h7FFF_FFFF)) a_des = {1'b0, {(VALUE_W-1){1'b1}}};
      else a_des = $signed(pm[VALUE_W-1:0]);
    end

    jl = $signed({2'b00, jlim_r});
    if (da_r > jl) dac = jl;
    else if (da_r < -jl) dac = -jl;
    else dac = da_r;

    alim = $signed({3'b000, accel_limit_r});
    if (sum_r > alim) a_lim = alim;
    else if (sum_r < -alim) a_lim = -alim;
    else a_lim = sum_r;

    step = prod_r[VALUE_W+FRAC_W-1:FRAC_W];
    sv   = neg_r ? -$signed({2'b00, step}) : $signed({2'b00, step});
    nv   = {{2{vel_sel[VALUE_W-1]}}, vel_sel} + sv;
    if (nv > $signed({3'b000, {(VALUE_W-1){1'b1}}})) vel_new = {1'b0, {(VALUE_W-1){1'b1}}};
    else if (nv < -$signed({3'b001, {(VALUE_W-1){1'b0}}}))
      vel_new = {1'b1, {(VALUE_W-1){1'b0}}};
    else vel_new = nv[VALUE_W-1:0];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      axis_r         <= 1'b0;
      accel_limit_r  <= ACCEL_LIMIT_RST;
      jerk_limit_r   <= JERK_LIMIT_RST;
      command_gain_r <= COMMAND_GAIN_RST;
      vel_r[0]       <= '0;
      vel_r[1]       <= '0;
      acc_r[0]       <= '0;
      acc_r[1]       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCEL_LIMIT:  accel_limit_r  <= cfg_data;
          CFG_JERK_LIMIT:   jerk_limit_r   <= cfg_data;
          CFG_COMMAND_GAIN: command_gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_JERK) axis_r <= 1'b0;
      if (state_r == ST_VADD) axis_r <= ~axis_r;
      if (state_r == ST_LIM)  acc_r[axis_r] <= a_lim[VALUE_W-1:0];
      if (state_r == ST_VADD) vel_r[axis_r] <= vel_new;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      xcmd_r <= in_if.x_command;
      ycmd_r <= in_if.y_command;
      dt_r   <= in_if.time_step;
    end
    case (state_r)
      ST_JERK: jlim_r <= mul_p[CFG_W+FRAC_W-1:FRAC_W];
      ST_ERR: begin
        neg_r <= err[VALUE_W];
        mag_r <= err[VALUE_W] ? VALUE_W'(-err) : err[VALUE_W-1:0];
      end
      ST_GMUL: prod_r <= mul_p;
      ST_DES:  da_r   <= {a_des[VALUE_W-1], a_des} - {acc_sel[VALUE_W-1], acc_sel};
      ST_ACC:  sum_r  <= {acc_sel[VALUE_W-1], acc_sel[VALUE_W-1], acc_sel}
                         + {dac[VALUE_W], dac};
      ST_LIM: begin
        neg_r <= a_lim[VALUE_W+1];
        mag_r <= a_lim[VALUE_W+1] ? VALUE_W'(-a_lim) : a_lim[VALUE_W-1:0];
      end
      ST_VMUL: prod_r <= mul_p;
      default: ;
    endcase
    if (out_load) begin
      x_out_r <= vel_r[0];
      y_out_r <= vel_r[1];
    end
  end

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.x_shaped = x_out_r;
  assign out_if.y_shaped = y_out_r;

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output step");

  a_acc_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LIM |=> mag_r <= {1'b0, accel_limit_r})
    else $error("acceleration beyond limit");

  a_jerk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_JERK |=> jlim_r <= jerk_limit_r)
    else $error("jerk bound above jerk limit");

endmodule
